// File: hw/rtl/bbl_pkg.sv
// Shared types and constants for the budgeted bus load balancer.
// Used by bbl_cell and budgeted_bus_load_balancer_core; no dependencies.
package bbl_pkg;

  localparam int MAX_BUSES  = 16;
  localparam int IDX_W      = (MAX_BUSES > 1) ? $clog2(MAX_BUSES) : 1;
  localparam int COST_W     = 32;
  localparam int BUS_CNT_W  = 5;
  localparam int OUT_IDX_W  = 4;
  localparam int ACTION_W   = 2;
  localparam int CFG_ADDR_W = 1;

  localparam int IN_FIELDS_W  = ACTION_W + 6 * COST_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + 4 * OUT_IDX_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CFG_ADDR_W-1:0] REG_BUS_COUNT = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_BUDGET    = CFG_ADDR_W'(1);

  typedef logic [IDX_W-1:0]  bbl_idx_t;
  typedef logic [COST_W-1:0] bbl_cost_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ACCUM = 2'd1,
    ACT_ADMIT = 2'd2,
    ACT_NONE  = 2'd3
  } bbl_action_t;

  typedef struct packed {
    logic      valid;
    logic      empty;
    bbl_cost_t a_val;
    bbl_idx_t  a_idx;
    bbl_cost_t b_val;
    bbl_idx_t  b_idx;
  } bbl_wave_t;

  typedef struct packed {
    logic      add_a;
    logic      add_b;
    bbl_cost_t cost_a;
    bbl_cost_t cost_b;
  } bbl_upd_t;

endpackage

// File: hw/rtl/budgeted_bus_load_balancer_core.sv
// Budgeted bus load balancer: a row of MAX_BUSES bus cells scanned by a wave
// that advances one cell per cycle. Depends on bbl_pkg and bbl_cell.
// A clear, reject or unused action goes from the check state straight to done;
// an applied item runs two scan waves across the cell row, each followed by an
// update. One item at a time; in_tready returns with out_tvalid, so an applied
// item holds the input until both scans are done and its result is out.
// Reset (rst_n low, synchronous): totals, committed sums and config registers zero.
module budgeted_bus_load_balancer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // action, cost_a_first, cost_b_first, cost_a_second, cost_b_second,
  // total_cost_a, total_cost_b (from bit 0 up)
  input  logic [bbl_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // admitted, bus_a_first, bus_b_first, bus_a_second, bus_b_second
  output logic [bbl_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [bbl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bbl_pkg::COST_W-1:0]        cfg_wdata
);
  import bbl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SCAN1, S_UPD1, S_LAUNCH2, S_SCAN2, S_UPD2, S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [BUS_CNT_W-1:0]   bus_count_r;
  bbl_cost_t              budget_r;
  bbl_cost_t              comm_a_r, comm_a_nxt;
  bbl_cost_t              comm_b_r, comm_b_nxt;
  logic [ACTION_W-1:0]    action_r;
  bbl_cost_t              ca1_r, cb1_r, ca2_r, cb2_r, tot_a_r, tot_b_r;
  bbl_idx_t               ia1_r, ib1_r, ia2_r, ib2_r;
  bbl_idx_t               ia1_nxt, ib1_nxt, ia2_nxt, ib2_nxt;
  logic                   adm_r, adm_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_FIELDS_W-1:0] out_data_r, out_data_nxt;

  bbl_wave_t              wave [0:MAX_BUSES];
  bbl_upd_t               upd  [MAX_BUSES];
  logic [MAX_BUSES-1:0]   active;
  logic                   launch, clr, apply;
  logic                   upd_first, upd_second;
  logic [COST_W+1:0]      check_sum;
  bbl_cost_t              cost_a, cost_b;
  bbl_idx_t               sel_a, sel_b;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    check_sum = {2'b00, comm_a_r} + {2'b00, comm_b_r}
              + {2'b00, tot_a_r} + {2'b00, tot_b_r};
    unique case (bbl_action_t'(action_r))
      ACT_ACCUM: apply = 1'b1;
      ACT_ADMIT: apply = (check_sum <= {2'b00, budget_r});
      default:   apply = 1'b0;
    endcase
  end

  assign clr        = (state_r == S_CHECK) && (bbl_action_t'(action_r) == ACT_CLEAR);
  assign launch     = ((state_r == S_CHECK) && apply) || (state_r == S_LAUNCH2);
  assign upd_first  = (state_r == S_UPD1);
  assign upd_second = (state_r == S_UPD2);
  assign cost_a     = upd_second ? ca2_r : ca1_r;
  assign cost_b     = upd_second ? cb2_r : cb1_r;
  assign sel_a      = upd_second ? ia2_r : ia1_r;
  assign sel_b      = upd_second ? ib2_r : ib1_r;

  always_comb begin
    wave[0]       = '0;
    wave[0].valid = launch;
    wave[0].empty = 1'b1;
  end

  for (genvar i = 0; i < MAX_BUSES; i++) begin : g_cell
    assign active[i]     = (32'(bus_count_r) > 32'(i));
    assign upd[i].add_a  = (upd_first || upd_second) && (sel_a == IDX_W'(i));
    assign upd[i].add_b  = (upd_first || upd_second) && (sel_b == IDX_W'(i));
    assign upd[i].cost_a = cost_a;
    assign upd[i].cost_b = cost_b;

    bbl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .active   (active[i]),
      .clr      (clr),
      .upd      (upd[i]),
      .wave_in  (wave[i]),
      .wave_out (wave[i+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    comm_a_nxt    = comm_a_r;
    comm_b_nxt    = comm_b_r;
    ia1_nxt       = ia1_r;
    ib1_nxt       = ib1_r;
    ia2_nxt       = ia2_r;
    ib2_nxt       = ib2_r;
    adm_nxt       = adm_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        adm_nxt = apply;
        ia1_nxt = '0;
        ib1_nxt = '0;
        ia2_nxt = '0;
        ib2_nxt = '0;
        if (clr) begin
          comm_a_nxt = '0;
          comm_b_nxt = '0;
        end
        state_nxt = apply ? S_SCAN1 : S_DONE;
      end
      S_SCAN1: begin
        if (wave[MAX_BUSES].valid) begin
          ia1_nxt   = wave[MAX_BUSES].a_idx;
          ib1_nxt   = wave[MAX_BUSES].b_idx;
          state_nxt = S_UPD1;
        end
      end
      S_UPD1: begin
        comm_a_nxt = comm_a_r + ca1_r;
        comm_b_nxt = comm_b_r + cb1_r;
        state_nxt  = S_LAUNCH2;
      end
      S_LAUNCH2: state_nxt = S_SCAN2;
      S_SCAN2: begin
        if (wave[MAX_BUSES].valid) begin
          ia2_nxt   = wave[MAX_BUSES].a_idx;
          ib2_nxt   = wave[MAX_BUSES].b_idx;
          state_nxt = S_UPD2;
        end
      end
      S_UPD2: begin
        comm_a_nxt = comm_a_r + ca2_r;
        comm_b_nxt = comm_b_r + cb2_r;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {OUT_IDX_W'(ib2_r), OUT_IDX_W'(ia2_r),
                           OUT_IDX_W'(ib1_r), OUT_IDX_W'(ia1_r), adm_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      comm_a_r    <= '0;
      comm_b_r    <= '0;
      bus_count_r <= '0;
      budget_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      comm_a_r    <= comm_a_nxt;
      comm_b_r    <= comm_b_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_BUS_COUNT: bus_count_r <= cfg_wdata[BUS_CNT_W-1:0];
          REG_BUDGET:    budget_r    <= cfg_wdata;
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      action_r <= in_tdata[ACTION_W-1:0];
      ca1_r    <= in_tdata[ACTION_W+0*COST_W +: COST_W];
      cb1_r    <= in_tdata[ACTION_W+1*COST_W +: COST_W];
      ca2_r    <= in_tdata[ACTION_W+2*COST_W +: COST_W];
      cb2_r    <= in_tdata[ACTION_W+3*COST_W +: COST_W];
      tot_a_r  <= in_tdata[ACTION_W+4*COST_W +: COST_W];
      tot_b_r  <= in_tdata[ACTION_W+5*COST_W +: COST_W];
    end
    ia1_r      <= ia1_nxt;
    ib1_r      <= ib1_nxt;
    ia2_r      <= ia2_nxt;
    ib2_r      <= ib2_nxt;
    adm_r      <= adm_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, out_data_r};

endmodule

// File: hw/rtl/bbl_cell.sv
// One bus cell: holds the A and B totals of a bus, joins the scan wave
// passing along the row and applies cost updates. Depends on bbl_pkg.
module bbl_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  bbl_pkg::bbl_idx_t  cell_idx,
  input  logic               active,
  input  logic               clr,
  input  bbl_pkg::bbl_upd_t  upd,
  input  bbl_pkg::bbl_wave_t wave_in,
  output bbl_pkg::bbl_wave_t wave_out
);
  import bbl_pkg::*;

  bbl_cost_t ta_r, ta_nxt;
  bbl_cost_t tb_r, tb_nxt;
  bbl_wave_t wave_r, wave_nxt;
  logic      take_a, take_b;

  always_comb begin
    take_a = active && (wave_in.empty || (ta_r <= wave_in.a_val));
    take_b = active && (wave_in.empty || (tb_r >= wave_in.b_val));
    wave_nxt = wave_in;
    wave_nxt.empty = wave_in.empty && !active;
    if (take_a) begin
      wave_nxt.a_val = ta_r;
      wave_nxt.a_idx = cell_idx;
    end
    if (take_b) begin
      wave_nxt.b_val = tb_r;
      wave_nxt.b_idx = cell_idx;
    end
  end

  always_comb begin
    ta_nxt = ta_r;
    tb_nxt = tb_r;
    if (clr) begin
      ta_nxt = '0;
      tb_nxt = '0;
    end else begin
      if (upd.add_a) ta_nxt = ta_r + upd.cost_a;
      if (upd.add_b) tb_nxt = tb_r + upd.cost_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ta_r   <= '0;
      tb_r   <= '0;
      wave_r <= '0;
    end else begin
      ta_r   <= ta_nxt;
      tb_r   <= tb_nxt;
      wave_r <= wave_nxt;
    end
  end

  assign wave_out = wave_r;

endmodule

// File: verif/tb_budgeted_bus_load_balancer_core.sv
// Self-checking testbench for budgeted_bus_load_balancer_core: drives slot transfers
// and register writes, predicts placements with a scoreboard class and checks each result.
// Depends on bbl_pkg and the core RTL only.
module tb_budgeted_bus_load_balancer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bbl_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 45;
  localparam int ITEMS_PER_SET  = 210;
  localparam int IDLE_PERCENT   = 7;

  typedef struct packed {
    bbl_cost_t   total_cost_b;
    bbl_cost_t   total_cost_a;
    bbl_cost_t   cost_b_second;
    bbl_cost_t   cost_a_second;
    bbl_cost_t   cost_b_first;
    bbl_cost_t   cost_a_first;
    bbl_action_t action;
  } slot_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] bus_b_second;
    logic [OUT_IDX_W-1:0] bus_a_second;
    logic [OUT_IDX_W-1:0] bus_b_first;
    logic [OUT_IDX_W-1:0] bus_a_first;
    logic                 admitted;
  } placement_t;

  class balancer_scoreboard;
    bbl_cost_t             totals_a [MAX_BUSES];
    bbl_cost_t             totals_b [MAX_BUSES];
    bbl_cost_t             committed_a;
    bbl_cost_t             committed_b;
    logic [BUS_CNT_W-1:0]  bus_count;
    bbl_cost_t             budget;
    placement_t            expected_placements[$];
    int                    mismatches;

    function new();
      clear_totals();
      bus_count   = '0;
      budget      = '0;
      mismatches  = 0;
    endfunction

    function void clear_totals();
      foreach (totals_a[i]) begin
        totals_a[i] = '0;
        totals_b[i] = '0;
      end
      committed_a = '0;
      committed_b = '0;
    endfunction

    function void set_register(logic [CFG_ADDR_W-1:0] addr, bbl_cost_t value);
      if (addr == REG_BUS_COUNT) begin
        bus_count = value[BUS_CNT_W-1:0];
      end else begin
        budget = value;
      end
    endfunction

    // Argmin of totals A and argmax of totals B, ties toward the higher index.
    function void place_costs(bbl_cost_t ca, bbl_cost_t cb,
                              output logic [OUT_IDX_W-1:0] ia,
                              output logic [OUT_IDX_W-1:0] ib);
      int n;
      int lo;
      int hi;
      n  = (bus_count > MAX_BUSES) ? MAX_BUSES : int'(bus_count);
      lo = 0;
      hi = 0;
      for (int i = 1; i < n; i++) begin
        if (totals_a[i] <= totals_a[lo]) lo = i;
        if (totals_b[i] >= totals_b[hi]) hi = i;
      end
      totals_a[lo] += ca;
      totals_b[hi] += cb;
      committed_a  += ca;
      committed_b  += cb;
      ia = OUT_IDX_W'(lo);
      ib = OUT_IDX_W'(hi);
    endfunction

    function void note_slot(slot_t s);
      placement_t  p;
      logic [33:0] demand;
      logic        fits;
      p    = '0;
      fits = 1'b0;
      case (s.action)
        ACT_CLEAR: clear_totals();
        ACT_ACCUM: fits = 1'b1;
        ACT_ADMIT: begin
          demand = 34'(committed_a) + 34'(committed_b) + 34'(s.total_cost_a)
                 + 34'(s.total_cost_b);
          fits = (demand <= 34'(budget));
        end
        default: ;
      endcase
      if (fits) begin
        p.admitted = 1'b1;
        place_costs(s.cost_a_first, s.cost_b_first, p.bus_a_first, p.bus_b_first);
        place_costs(s.cost_a_second, s.cost_b_second, p.bus_a_second, p.bus_b_second);
      end
      expected_placements.push_back(p);
    endfunction

    function void check_result(placement_t got);
      placement_t want;
      if (expected_placements.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = expected_placements.pop_front();
      if (got.admitted !== want.admitted || got.bus_a_first !== want.bus_a_first ||
          got.bus_b_first !== want.bus_b_first || got.bus_a_second !== want.bus_a_second ||
          got.bus_b_second !== want.bus_b_second) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: admitted %0d/%0d a1 %0d/%0d b1 %0d/%0d a2 %0d/%0d b2 %0d/%0d",
                   want.admitted, got.admitted, want.bus_a_first, got.bus_a_first,
                   want.bus_b_first, got.bus_b_first, want.bus_a_second, got.bus_a_second,
                   want.bus_b_second, got.bus_b_second);
        end
      end
    endfunction

    function int pending();
      return expected_placements.size();
    endfunction
  endclass

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata   = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr   = '0;
  logic [COST_W-1:0]       cfg_wdata  = '0;

  logic                    steady     = 1'b0;
  int                      cycles     = 0;
  balancer_scoreboard      sb         = new();

  budgeted_bus_load_balancer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL budgeted_bus_load_balancer_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(placement_t'(out_tdata[OUT_FIELDS_W-1:0]));
    end
  end

  function automatic slot_t make_slot(bbl_action_t act, bbl_cost_t caf, bbl_cost_t cbf,
                                      bbl_cost_t cas, bbl_cost_t cbs,
                                      bbl_cost_t tca, bbl_cost_t tcb);
    slot_t s;
    s.action        = act;
    s.cost_a_first  = caf;
    s.cost_b_first  = cbf;
    s.cost_a_second = cas;
    s.cost_b_second = cbs;
    s.total_cost_a  = tca;
    s.total_cost_b  = tcb;
    return s;
  endfunction

  // Mostly small costs so ties and budget limits are hit; some full-range for wrap.
  function automatic bbl_cost_t random_cost();
    case ($urandom_range(3))
      0, 1:    return bbl_cost_t'($urandom_range(7));
      2:       return bbl_cost_t'($urandom_range(1000));
      default: return bbl_cost_t'($urandom);
    endcase
  endfunction

  function automatic slot_t random_slot();
    int          pick;
    bbl_action_t act;
    pick = $urandom_range(99);
    if (pick < 6)       act = ACT_CLEAR;
    else if (pick < 45) act = ACT_ACCUM;
    else if (pick < 92) act = ACT_ADMIT;
    else                act = ACT_NONE;
    return make_slot(act, random_cost(), random_cost(), random_cost(), random_cost(),
                     random_cost(), random_cost());
  endfunction

  task automatic send_slot(slot_t s);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(s);
    do @(posedge clk); while (!in_tready);
    sb.note_slot(s);
  endtask

  // Hold input idle until every placement is back, then let the core settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_registers(logic [BUS_CNT_W-1:0] count, bbl_cost_t limit);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_BUS_COUNT;
    cfg_wdata <= COST_W'(count);
    @(posedge clk);
    sb.set_register(REG_BUS_COUNT, COST_W'(count));
    cfg_addr  <= REG_BUDGET;
    cfg_wdata <= limit;
    @(posedge clk);
    sb.set_register(REG_BUDGET, limit);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random(int count);
    repeat (count) send_slot(random_slot());
    drain();
  endtask

  initial begin
    bbl_cost_t ones;
    ones = '1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_registers(5'd4, 32'd100);
    send_slot(make_slot(ACT_ACCUM, 0, 0, 0, 0, 0, 0));
    send_slot(make_slot(ACT_ACCUM, 5, 5, 1, 1, 0, 0));
    send_slot(make_slot(ACT_ACCUM, ones, ones, ones, ones, ones, ones));
    send_slot(make_slot(ACT_ACCUM, ones, ones, ones, ones, ones, ones));
    send_slot(make_slot(ACT_ADMIT, 1, 1, 1, 1, ones, ones));
    send_slot(make_slot(ACT_CLEAR, ones, ones, ones, ones, ones, ones));
    send_slot(make_slot(ACT_ADMIT, 10, 10, 10, 10, 50, 50));
    send_slot(make_slot(ACT_ADMIT, 3, 7, 2, 9, 30, 30));
    send_slot(make_slot(ACT_ADMIT, 1, 1, 1, 1, 31, 30));
    send_slot(make_slot(ACT_NONE, ones, ones, ones, ones, 0, 0));
    send_slot(make_slot(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
    send_slot(make_slot(ACT_ADMIT, 0, 0, 0, 0, 0, 0));
    send_slot(make_slot(ACT_ADMIT, ones, 0, 0, ones, 0, 100));
    drain();

    steady = 1'b1;
    program_registers(5'd16, 32'hFFFF_FFFF);
    run_random(ITEMS_PER_SET);
    steady = 1'b0;

    program_registers(5'd0, 32'd0);
    run_random(ITEMS_PER_SET);

    program_registers(5'd31, bbl_cost_t'($urandom_range(20000)));
    run_random(ITEMS_PER_SET);

    program_registers(5'd1, bbl_cost_t'($urandom));
    run_random(ITEMS_PER_SET);

    program_registers(BUS_CNT_W'($urandom_range(2, 15)), bbl_cost_t'($urandom_range(100, 5000)));
    run_random(ITEMS_PER_SET);

    program_registers(5'd16, 32'd1000);
    run_random(ITEMS_PER_SET);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS budgeted_bus_load_balancer_core");
    end else begin
      $display("FAIL budgeted_bus_load_balancer_core");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bbl_pkg.sv
hw/rtl/bbl_cell.sv
hw/rtl/budgeted_bus_load_balancer_core.sv
verif/tb_budgeted_bus_load_balancer_core.sv
